>>> rtl/core/min_max_column_normalizer_defines.svh
// Assertion helpers shared by the normalizer RTL.
`ifndef MIN_MAX_COLUMN_NORMALIZER_DEFINES_SVH
`define MIN_MAX_COLUMN_NORMALIZER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MMCN_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MMCN_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/core/mmcn_pkg.sv
package mmcn_pkg;

   localparam int SAMPLE_W = 32;
   localparam int INDEX_W  = 12;
   localparam int NORM_W   = 17;
   localparam int CSR_W    = 4;

   localparam logic [1:0] OP_LOAD  = 2'd0;
   localparam logic [1:0] OP_READ  = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;

   localparam logic [1:0] ST_OK         = 2'd0;
   localparam logic [1:0] ST_ZERO_SPAN  = 2'd1;
   localparam logic [1:0] ST_NOT_LOADED = 2'd2;
   localparam logic [1:0] ST_FULL       = 2'd3;

   // Values that an empty column's bounds read as.
   localparam logic signed [SAMPLE_W-1:0] EMPTY_MIN = 32'sh7FFF_FFFF;
   localparam logic signed [SAMPLE_W-1:0] EMPTY_MAX = 32'sh8000_0000;

   typedef struct packed {
      logic [1:0]                 operation;
      logic signed [SAMPLE_W-1:0] sample;
      logic [INDEX_W-1:0]         entry_index;
   } req_type;

   typedef struct packed {
      logic [NORM_W-1:0] normalized;
      logic [1:0]        status;
   } rsp_type;

endpackage

>>> rtl/core/min_max_column_normalizer.sv
// Responses: a clear, a rejected load, a read of an unloaded entry or an unused code responds
// from the idle state; a stored load responds after the load update state; a read of a column
// with zero span responds after store read, bounds read and span setup; any other read then
// also runs 17 steps of the shared restoring divider, one quotient bit per step.
// Flow: no new item is taken while a load or read is in progress; results cannot be stalled.
// Reset (synchronous, active high) empties the data set and sets column_count to 1; the
// sample store is not cleared, since only entries below the loaded count are ever read.
`include "min_max_column_normalizer_defines.svh"

module min_max_column_normalizer
   import mmcn_pkg::*;
#(
   parameter int MAX_COLUMNS = 8,
   parameter int STORE_DEPTH = 4096
)
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  req_type          req_payload,
   output logic             rsp_valid,
   output rsp_type          rsp_payload,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [CSR_W-1:0] csr_data
);

   // Widths that follow from the two size parameters.
   localparam int TAG_W     = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
   localparam int ADDR_W    = $clog2(STORE_DEPTH);
   localparam int CNT_W     = $clog2(STORE_DEPTH + 1);
   localparam int CMP_W     = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;
   localparam int EFF_W     = ($clog2(MAX_COLUMNS + 1) > CSR_W) ?
                              $clog2(MAX_COLUMNS + 1) : CSR_W;
   localparam int ENTRY_W   = SAMPLE_W + TAG_W;
   localparam int BND_W     = 2 * SAMPLE_W;
   localparam int STEP_W    = $clog2(NORM_W);

   // Sequencer state codes.
   localparam int STATE_W = 3;
   localparam logic [STATE_W-1:0] S_IDLE     = 3'd0;
   localparam logic [STATE_W-1:0] S_LOAD_UPD = 3'd1;
   localparam logic [STATE_W-1:0] S_RD_BND   = 3'd2;
   localparam logic [STATE_W-1:0] S_RD_SPAN  = 3'd3;
   localparam logic [STATE_W-1:0] S_DIV      = 3'd4;

   // Control registers.
   logic [STATE_W-1:0]     state_ff, state_in;
   logic [CSR_W-1:0]       col_count_ff, col_count_in;
   logic [CNT_W-1:0]       loaded_ff, loaded_in;
   logic [TAG_W-1:0]       next_col_ff, next_col_in;
   logic [MAX_COLUMNS-1:0] bnd_valid_ff, bnd_valid_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   // Datapath registers.
   logic signed [SAMPLE_W-1:0] sample_ff, sample_in;
   logic [TAG_W-1:0]           col_ff, col_in;
   logic [SAMPLE_W:0]          rem_ff, rem_in;
   logic [SAMPLE_W-1:0]        span_ff, span_in;
   logic [NORM_W-1:0]          quot_ff, quot_in;
   logic [STEP_W-1:0]          step_ff, step_in;
   rsp_type                    rsp_ff, rsp_in;

   // Memories and their registered read data. Each store entry holds its column tag above
   // the sample; each bounds entry holds the column maximum above the column minimum.
   logic [ENTRY_W-1:0] store_mem [STORE_DEPTH];
   logic [ENTRY_W-1:0] store_rd_ff;
   logic [BND_W-1:0]   bnd_mem [MAX_COLUMNS];
   logic [BND_W-1:0]   bnd_rd_ff;
   logic               bnd_rd_vld_ff;

   logic               accept;
   logic               store_full;
   logic               idx_loaded;
   logic [CMP_W-1:0]   idx_ext;
   logic [EFF_W-1:0]   eff_cols;
   logic [EFF_W-1:0]   load_col_ext;
   logic [EFF_W-1:0]   col_plus;
   logic [TAG_W-1:0]   load_col;
   logic               store_we;
   logic               store_re;
   logic               bnd_we;
   logic               bnd_re;
   logic [TAG_W-1:0]   bnd_raddr;
   logic [BND_W-1:0]   bnd_wdata;

   logic signed [SAMPLE_W-1:0] col_lo;
   logic signed [SAMPLE_W-1:0] col_hi;
   logic signed [SAMPLE_W-1:0] new_lo;
   logic signed [SAMPLE_W-1:0] new_hi;
   logic signed [SAMPLE_W-1:0] rd_value;
   logic signed [SAMPLE_W:0]   span_wide;
   logic signed [SAMPLE_W:0]   off_wide;
   logic [SAMPLE_W:0]          off_clamped;
   logic                       div_ge;
   logic [SAMPLE_W:0]          div_diff;

   assign busy        = (state_ff != S_IDLE);
   assign accept      = start && !busy;
   assign csr_ready   = !busy;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // The register value zero acts as one column, anything above the maximum as the maximum.
   always_comb begin
      if (col_count_ff == '0) begin
         eff_cols = EFF_W'(1);
      end else if (EFF_W'(col_count_ff) > EFF_W'(MAX_COLUMNS)) begin
         eff_cols = EFF_W'(MAX_COLUMNS);
      end else begin
         eff_cols = EFF_W'(col_count_ff);
      end
   end

   // A shrunken column count can leave the next column out of range; it then wraps to zero.
   assign load_col_ext = (EFF_W'(next_col_ff) >= eff_cols) ? '0 : EFF_W'(next_col_ff);
   assign load_col     = load_col_ext[TAG_W-1:0];
   assign col_plus     = EFF_W'(col_ff) + EFF_W'(1);

   assign store_full = (loaded_ff == CNT_W'(STORE_DEPTH));
   assign idx_ext    = CMP_W'(req_payload.entry_index);
   assign idx_loaded = (idx_ext < CMP_W'(loaded_ff));

   // A stored load writes the store at the accepting edge and reads its column bounds there too.
   assign store_we  = accept && (req_payload.operation == OP_LOAD) && !store_full;
   assign store_re  = accept && (req_payload.operation == OP_READ) && idx_loaded;
   assign bnd_re    = store_we || (state_ff == S_RD_BND);
   assign bnd_raddr = (state_ff == S_IDLE) ? load_col : store_rd_ff[ENTRY_W-1:SAMPLE_W];
   assign bnd_we    = (state_ff == S_LOAD_UPD);

   // A column with no valid bounds reads as the empty bounds.
   assign col_lo = bnd_rd_vld_ff ? $signed(bnd_rd_ff[SAMPLE_W-1:0]) : EMPTY_MIN;
   assign col_hi = bnd_rd_vld_ff ? $signed(bnd_rd_ff[BND_W-1:SAMPLE_W]) : EMPTY_MAX;
   assign new_lo = (sample_ff < col_lo) ? sample_ff : col_lo;
   assign new_hi = (sample_ff > col_hi) ? sample_ff : col_hi;
   assign bnd_wdata = {new_hi, new_lo};

   // Span and offset are taken one bit wider so that no difference can overflow. The offset
   // is clamped into the range zero to span, which keeps the quotient at or below one.
   assign rd_value    = $signed(store_rd_ff[SAMPLE_W-1:0]);
   assign span_wide   = {col_hi[SAMPLE_W-1], col_hi} - {col_lo[SAMPLE_W-1], col_lo};
   assign off_wide    = {rd_value[SAMPLE_W-1], rd_value} - {col_lo[SAMPLE_W-1], col_lo};
   assign off_clamped = off_wide[SAMPLE_W] ? '0 :
                        ((off_wide > span_wide) ? span_wide : off_wide);

   // One restoring step: compare the partial remainder with the span, subtract on success.
   assign div_ge   = (rem_ff >= {1'b0, span_ff});
   assign div_diff = div_ge ? (rem_ff - {1'b0, span_ff}) : rem_ff;

   always_comb begin
      state_in     = state_ff;
      col_count_in = col_count_ff;
      loaded_in    = loaded_ff;
      next_col_in  = next_col_ff;
      bnd_valid_in = bnd_valid_ff;
      rsp_valid_in = 1'b0;
      sample_in    = sample_ff;
      col_in       = col_ff;
      rem_in       = rem_ff;
      span_in      = span_ff;
      quot_in      = quot_ff;
      step_in      = step_ff;
      rsp_in       = rsp_ff;

      if (csr_valid && csr_ready) begin
         col_count_in = csr_data;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               // Every item that needs no memory data answers right away.
               rsp_in.normalized = '0;
               rsp_in.status     = ST_OK;
               unique case (req_payload.operation)
                  OP_LOAD: begin
                     if (store_full) begin
                        rsp_valid_in  = 1'b1;
                        rsp_in.status = ST_FULL;
                     end else begin
                        sample_in = req_payload.sample;
                        col_in    = load_col;
                        state_in  = S_LOAD_UPD;
                     end
                  end
                  OP_READ: begin
                     if (idx_loaded) begin
                        state_in = S_RD_BND;
                     end else begin
                        rsp_valid_in  = 1'b1;
                        rsp_in.status = ST_NOT_LOADED;
                     end
                  end
                  OP_CLEAR: begin
                     loaded_in    = '0;
                     next_col_in  = '0;
                     bnd_valid_in = '0;
                     rsp_valid_in = 1'b1;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         S_LOAD_UPD: begin
            // The merged bounds are written back in this cycle by the bounds memory.
            bnd_valid_in[col_ff] = 1'b1;
            loaded_in            = loaded_ff + CNT_W'(1);
            next_col_in          = (col_plus >= eff_cols) ? '0 : col_plus[TAG_W-1:0];
            rsp_valid_in         = 1'b1;
            state_in             = S_IDLE;
         end
         S_RD_BND: begin
            // Store data is registered; the bounds of its column are read now.
            state_in = S_RD_SPAN;
         end
         S_RD_SPAN: begin
            if (col_hi <= col_lo) begin
               rsp_valid_in  = 1'b1;
               rsp_in.status = ST_ZERO_SPAN;
               state_in      = S_IDLE;
            end else begin
               span_in  = span_wide[SAMPLE_W-1:0];
               rem_in   = off_clamped;
               quot_in  = '0;
               step_in  = '0;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            // The remainder stays below the span, so its doubled value fits the register.
            rem_in  = {div_diff[SAMPLE_W-1:0], 1'b0};
            quot_in = {quot_ff[NORM_W-2:0], div_ge};
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(NORM_W - 1)) begin
               rsp_valid_in      = 1'b1;
               rsp_in.normalized = {quot_ff[NORM_W-2:0], div_ge};
               state_in          = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         col_count_ff <= CSR_W'(1);
         loaded_ff    <= '0;
         next_col_ff  <= '0;
         bnd_valid_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         col_count_ff <= col_count_in;
         loaded_ff    <= loaded_in;
         next_col_ff  <= next_col_in;
         bnd_valid_ff <= bnd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff <= sample_in;
      col_ff    <= col_in;
      rem_ff    <= rem_in;
      span_ff   <= span_in;
      quot_ff   <= quot_in;
      step_ff   <= step_in;
      rsp_ff    <= rsp_in;
   end

   // Sample store: one write port at the fill position, one registered read port.
   always_ff @(posedge clock) begin
      if (store_we) begin
         store_mem[loaded_ff[ADDR_W-1:0]] <= {load_col, req_payload.sample};
      end
      if (store_re) begin
         store_rd_ff <= store_mem[idx_ext[ADDR_W-1:0]];
      end
   end

   // Column bounds: written once per stored load, read once per stored load or read of a loaded entry.
   always_ff @(posedge clock) begin
      if (bnd_we) begin
         bnd_mem[col_ff] <= bnd_wdata;
      end
      if (bnd_re) begin
         bnd_rd_ff     <= bnd_mem[bnd_raddr];
         bnd_rd_vld_ff <= bnd_valid_ff[bnd_raddr];
      end
   end

   `MMCN_ASSERT_NOW(a_rsp_only_when_idle, rsp_valid_ff, (state_ff == S_IDLE), "response outside idle")
   `MMCN_ASSERT_NOW(a_norm_zero_on_error, (rsp_valid_ff && (rsp_ff.status != ST_OK)), (rsp_ff.normalized == '0), "nonzero result on error")
   `MMCN_ASSERT_NEXT(a_read_enters_work, (store_re), (state_ff == S_RD_BND), "read did not start")
   `MMCN_ASSERT_NOW(a_div_remainder_bound, (state_ff == S_DIV), ((span_ff != '0) && (rem_ff < {span_ff, 1'b0})), "divider remainder out of range")
   `MMCN_ASSERT_NOW(a_count_bound, 1'b1, (loaded_ff <= CNT_W'(STORE_DEPTH)), "loaded count past store depth")

endmodule

>>> tb/min_max_column_normalizer_tb.sv
`timescale 1ns / 100ps

// Self-checking bench for the min-max column normalizer. Items go in through the
// start/busy command port; every item produces exactly one response strobe. A
// scoreboard predicts each response when the item is accepted and the response
// checker compares the strobed payload against the oldest prediction.
module min_max_column_normalizer_tb;
   import mmcn_pkg::*;

   localparam int MAX_COLUMNS = 8;
   localparam int STORE_DEPTH = 4096;

   // Operation code 3 has no meaning in the block; it must be answered and otherwise ignored.
   localparam logic [1:0] OP_UNUSED = 2'd3;

   // The limit sits well above the slowest legal run, so this only trips on a hang.
   localparam int CYCLE_LIMIT = 1_000_000;

   // This covers any trailing response after the final drain.
   localparam int SETTLE_CYCLES = 40;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             start = 1'b0;
   logic             busy;
   req_type          req_payload = '0;
   logic             rsp_valid;
   rsp_type          rsp_payload;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic [CSR_W-1:0] csr_data = '0;

   min_max_column_normalizer #(
      .MAX_COLUMNS(MAX_COLUMNS),
      .STORE_DEPTH(STORE_DEPTH)
   ) uut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data)
   );

   always #1 clock = ~clock;

   // Shadow copy of the block's data set, column bounds and column register.
   logic signed [SAMPLE_W-1:0] shadow_samples [STORE_DEPTH];
   logic [2:0]                 shadow_tags [STORE_DEPTH];
   logic signed [SAMPLE_W-1:0] shadow_col_min [MAX_COLUMNS];
   logic signed [SAMPLE_W-1:0] shadow_col_max [MAX_COLUMNS];
   int unsigned                shadow_count;
   int unsigned                shadow_next_col;
   logic [CSR_W-1:0]           shadow_col_setting;

   // Predicted responses, oldest first.
   rsp_type pending_normalizations[$];
   rsp_type wanted;

   int idle_percent = 0;
   int failures = 0;
   int results_checked = 0;
   int status_seen [4] = '{default: 0};
   int cycle_count = 0;
   int settings_used = 0;
   logic signed [SAMPLE_W-1:0] last_sample = '0;

   // A clear returns every column to its empty bounds and restarts the load pointer.
   function automatic void clear_shadow_set();
      for (int c = 0; c < MAX_COLUMNS; c++) begin
         shadow_col_min[c] = EMPTY_MIN;
         shadow_col_max[c] = EMPTY_MAX;
      end
      shadow_count = 0;
      shadow_next_col = 0;
   endfunction

   // Computes the response the block owes for one item and advances the shadow state.
   function automatic rsp_type predict_normalization(input req_type item);
      rsp_type           outcome;
      int unsigned       cols;
      int unsigned       col;
      int unsigned       idx;
      longint            lo;
      longint            hi;
      longint            delta;
      longint unsigned   span;
      longint unsigned   offset;
      longint unsigned   quotient;
      outcome.normalized = '0;
      outcome.status = ST_OK;
      case (item.operation)
         OP_LOAD: begin
            if (shadow_count >= STORE_DEPTH) begin
               outcome.status = ST_FULL;
            end else begin
               // Register values outside 1..MAX_COLUMNS are clamped into range.
               if (shadow_col_setting == 0)
                  cols = 1;
               else if (shadow_col_setting > MAX_COLUMNS)
                  cols = MAX_COLUMNS;
               else
                  cols = 32'(shadow_col_setting);
               // A column count lowered mid-row sends the pointer back to column 0.
               col = (shadow_next_col >= cols) ? 0 : shadow_next_col;
               shadow_samples[shadow_count] = item.sample;
               shadow_tags[shadow_count] = 3'(col);
               if ($signed(item.sample) < shadow_col_min[col])
                  shadow_col_min[col] = item.sample;
               if ($signed(item.sample) > shadow_col_max[col])
                  shadow_col_max[col] = item.sample;
               shadow_count++;
               col++;
               shadow_next_col = (col >= cols) ? 0 : col;
            end
         end
         OP_READ: begin
            idx = 32'(item.entry_index);
            if (idx >= shadow_count) begin
               outcome.status = ST_NOT_LOADED;
            end else begin
               col = 32'(shadow_tags[idx]);
               lo = shadow_col_min[col];
               hi = shadow_col_max[col];
               if (hi <= lo) begin
                  outcome.status = ST_ZERO_SPAN;
               end else begin
                  span = longint'(hi - lo);
                  delta = longint'(shadow_samples[idx]) - lo;
                  offset = (delta < 0) ? 0 : delta;
                  if (offset > span)
                     offset = span;
                  quotient = (offset << 16) / span;
                  if (quotient > 65536)
                     quotient = 65536;
                  outcome.normalized = quotient[NORM_W-1:0];
               end
            end
         end
         OP_CLEAR: clear_shadow_set();
         default: ;
      endcase
      return outcome;
   endfunction

   function automatic req_type make_item(input logic [1:0] op,
                                         input logic [SAMPLE_W-1:0] value,
                                         input logic [INDEX_W-1:0] idx);
      req_type item;
      item.operation = op;
      item.sample = value;
      item.entry_index = idx;
      return item;
   endfunction

   // Random traffic is mostly loads and reads of loaded entries, so that
   // columns fill up and real divisions happen. Sample values mix wide random
   // values, clustered values, the extremes and repeats (for flat columns).
   function automatic req_type random_item();
      req_type item;
      int      pick;
      int      nudge;
      item.operation = OP_LOAD;
      item.sample = $urandom;
      item.entry_index = INDEX_W'($urandom);
      pick = $urandom_range(0, 99);
      nudge = int'($urandom_range(0, 2000)) - 1000;
      if (pick < 42) begin
         case ($urandom_range(0, 9))
            0, 1, 2: item.sample = $urandom;
            3, 4, 5: item.sample = int'($urandom_range(0, 200000)) - 100000;
            6: begin
               case ($urandom_range(0, 3))
                  0: item.sample = 32'sh7FFF_FFFF;
                  1: item.sample = 32'sh8000_0000;
                  2: item.sample = '0;
                  default: item.sample = '1;
               endcase
            end
            7: item.sample = last_sample;
            default: item.sample = last_sample + nudge;
         endcase
         last_sample = item.sample;
      end else if (pick < 94) begin
         item.operation = OP_READ;
         if (shadow_count > 0 && $urandom_range(0, 9) < 8)
            item.entry_index = INDEX_W'($urandom_range(0, shadow_count - 1));
      end else if (pick < 97) begin
         item.operation = OP_CLEAR;
      end else begin
         item.operation = OP_UNUSED;
      end
      return item;
   endfunction

   // Presents one item and holds it until the block takes it. After acceptance
   // start stays high unless the sender decides to idle, so back-to-back items
   // never lower and raise start within one time step.
   task automatic send_item(input req_type item);
      int gap;
      start <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (busy);
      pending_normalizations.push_back(predict_normalization(item));
      if ($urandom_range(1, 100) <= idle_percent) begin
         gap = $urandom_range(1, 24);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Stops sending and waits for every predicted response to come back.
   task automatic drain_responses();
      start <= 1'b0;
      while (pending_normalizations.size() != 0 || busy)
         @(posedge clock);
   endtask

   // The column register is only touched once the block has gone quiet.
   task automatic write_column_count(input logic [CSR_W-1:0] value);
      drain_responses();
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      shadow_col_setting = value;
      settings_used++;
      csr_valid <= 1'b0;
   endtask

   // One column holding both extremes spans the full 32-bit range; a read of
   // its minimum must give 0, its maximum exactly 1.0, and the midpoint half.
   task automatic test_extreme_bounds();
      write_column_count(4'd1);
      send_item(make_item(OP_CLEAR, '0, '0));
      send_item(make_item(OP_READ, '1, 12'd0));
      send_item(make_item(OP_LOAD, 32'h8000_0000, 12'hFFF));
      send_item(make_item(OP_READ, '0, 12'd0));
      send_item(make_item(OP_LOAD, 32'h7FFF_FFFF, 12'd0));
      send_item(make_item(OP_LOAD, 32'h0000_0000, 12'd0));
      send_item(make_item(OP_READ, '0, 12'd0));
      send_item(make_item(OP_READ, '0, 12'd1));
      send_item(make_item(OP_READ, '0, 12'd2));
      send_item(make_item(OP_READ, '0, 12'd3));
      send_item(make_item(OP_READ, '0, 12'hFFF));
      send_item(make_item(OP_UNUSED, 32'h7FFF_FFFF, 12'hFFF));
      send_item(make_item(OP_READ, '0, 12'd1));
      send_item(make_item(OP_CLEAR, '1, '1));
      send_item(make_item(OP_READ, '0, 12'd0));
   endtask

   // Lowering the column count mid-row must wrap the load pointer, and
   // register values of 0 and above eight must clamp.
   task automatic test_column_wrap();
      write_column_count(4'd5);
      send_item(make_item(OP_CLEAR, '0, '0));
      for (int k = 0; k < 4; k++)
         send_item(make_item(OP_LOAD, 32'(k * 1000 - 1500), '0));
      write_column_count(4'd2);
      send_item(make_item(OP_LOAD, 32'h0001_0000, '0));
      send_item(make_item(OP_LOAD, 32'hFFFF_0000, '0));
      send_item(make_item(OP_READ, '0, 12'd4));
      write_column_count(4'd0);
      send_item(make_item(OP_LOAD, 32'h0000_8000, '0));
      send_item(make_item(OP_READ, '0, 12'd6));
      write_column_count(4'd15);
      for (int k = 0; k < 9; k++)
         send_item(make_item(OP_LOAD, $urandom, '0));
      send_item(make_item(OP_READ, '0, 12'd15));
      write_column_count(4'd9);
      send_item(make_item(OP_LOAD, 32'h7FFF_FFFF, '0));
      send_item(make_item(OP_READ, '0, 12'd7));
   endtask

   // One random phase at a given column setting and sender idle rate. The data
   // set is only sometimes cleared first, so leftovers from the last setting
   // carry over and exercise the pointer wrap. The phase ends with a full drain.
   task automatic test_random_phase(input logic [CSR_W-1:0] setting, input int idle,
                                    input int count);
      write_column_count(setting);
      idle_percent = idle;
      if ($urandom_range(0, 1) == 0)
         send_item(make_item(OP_CLEAR, $urandom, INDEX_W'($urandom)));
      for (int k = 0; k < count; k++)
         send_item(random_item());
      drain_responses();
   endtask

   // Response checker: each strobe is matched against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (pending_normalizations.size() == 0) begin
            $error("response with no item outstanding: normalized %0d status %0d",
                   rsp_payload.normalized, rsp_payload.status);
            failures++;
         end else begin
            wanted = pending_normalizations.pop_front();
            results_checked++;
            status_seen[wanted.status]++;
            if (rsp_payload.normalized !== wanted.normalized) begin
               $error("normalized: expected %0d, got %0d",
                      wanted.normalized, rsp_payload.normalized);
               failures++;
            end
            if (rsp_payload.status !== wanted.status) begin
               $error("status: expected %0d, got %0d", wanted.status, rsp_payload.status);
               failures++;
            end
         end
      end
   end

   // Watchdog against a hung handshake.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("min_max_column_normalizer: mismatch");
         $finish;
      end
   end

   initial begin
      shadow_col_setting = 4'd1;
      clear_shadow_set();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_extreme_bounds();
      test_column_wrap();

      // Phases cycle through the sender idle rates, with the column register
      // at its extremes and a random setting at the end.
      test_random_phase(4'd8, 0, 290);
      test_random_phase(4'd1, 49, 290);
      test_random_phase(4'd4, 15, 290);
      test_random_phase(4'd15, 49, 290);
      test_random_phase(4'd0, 0, 290);
      test_random_phase(4'($urandom_range(2, 7)), 15, 290);

      drain_responses();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Checked %0d responses across %0d column settings in %0d cycles.",
               results_checked, settings_used, cycle_count);
      $display("Statuses seen: ok %0d, zero span %0d, not loaded %0d, store full %0d.",
               status_seen[ST_OK], status_seen[ST_ZERO_SPAN],
               status_seen[ST_NOT_LOADED], status_seen[ST_FULL]);
      if (failures == 0)
         $display("min_max_column_normalizer: match");
      else
         $display("min_max_column_normalizer: mismatch");
      $finish;
   end

endmodule
